>>> rtl/cka_pkg.sv
// shared constants, operation and status codes and the control record
// passed along the cell chain; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cka_pkg;
	localparam int DATA_WIDTH = 32;

	localparam logic [2:0] FUNC_CMP = 3'd0;
	localparam logic [2:0] FUNC_ADD = 3'd1;
	localparam logic [2:0] FUNC_SUB = 3'd2;
	localparam logic [2:0] FUNC_MUL = 3'd3;
	localparam logic [2:0] FUNC_DIV = 3'd4;
	localparam logic [2:0] FUNC_MOD = 3'd5;
	localparam logic [2:0] FUNC_POW = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		logic       direct;  // result already settled in the decode stage
		logic       neg;     // sign of the magnitude result
		logic [1:0] status;
	} ctl_t;
endpackage
`default_nettype wire

>>> rtl/cka_prep.sv
// decode stage: magnitudes, compare/add/sub and all special cases
// depends on cka_pkg
`timescale 1ns / 1ps
`default_nettype none
module cka_prep #(
	parameter int W = cka_pkg::DATA_WIDTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               valid_i,
	input  wire  [2:0]        func,
	input  wire  [W-1:0]      operand_a,
	input  wire  [W-1:0]      operand_b,
	output logic              valid_s1,
	output cka_pkg::ctl_t     ctl_s1,
	output logic [W-1:0]      ma_s1,
	output logic [W-1:0]      mb_s1,
	output logic [W-1:0]      dval_s1
);
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_V = W'(1);
	localparam logic [W-1:0] WCNT  = W'(W);

	logic [W-1:0]  ma, mb;
	logic [W:0]    sum, diff;
	logic [W-1:0]  cmp_v;
	cka_pkg::ctl_t ctl;
	logic [W-1:0]  dval;

	assign ma   = operand_a[W-1] ? (~operand_a + ONE_V) : operand_a;
	assign mb   = operand_b[W-1] ? (~operand_b + ONE_V) : operand_b;
	assign sum  = {operand_a[W-1], operand_a} + {operand_b[W-1], operand_b};
	assign diff = {operand_a[W-1], operand_a} - {operand_b[W-1], operand_b};
	assign cmp_v = (operand_a == operand_b) ? '0 :
		($signed(operand_a) < $signed(operand_b)) ? '1 : ONE_V;

	always_comb begin
		ctl.func   = func;
		ctl.direct = 1'b1;
		ctl.neg    = 1'b0;
		ctl.status = cka_pkg::ST_OK;
		dval       = '0;
		case (func)
			cka_pkg::FUNC_CMP: dval = cmp_v;
			cka_pkg::FUNC_ADD: begin
				if (sum[W] ^ sum[W-1]) ctl.status = cka_pkg::ST_RANGE;
				else dval = sum[W-1:0];
			end
			cka_pkg::FUNC_SUB: begin
				if (diff[W] ^ diff[W-1]) ctl.status = cka_pkg::ST_RANGE;
				else dval = diff[W-1:0];
			end
			cka_pkg::FUNC_MUL: begin
				ctl.direct = 1'b0;
				ctl.neg    = operand_a[W-1] ^ operand_b[W-1];
			end
			cka_pkg::FUNC_DIV: begin
				if (operand_b == '0) ctl.status = cka_pkg::ST_ZERO;
				else if (operand_a == MIN_V && operand_b == '1) ctl.status = cka_pkg::ST_RANGE;
				else begin
					ctl.direct = 1'b0;
					ctl.neg    = operand_a[W-1] ^ operand_b[W-1];
				end
			end
			cka_pkg::FUNC_MOD: begin
				if (operand_b == '0) ctl.status = cka_pkg::ST_ZERO;
				else begin
					ctl.direct = 1'b0;
					ctl.neg    = operand_a[W-1];
				end
			end
			cka_pkg::FUNC_POW: begin
				if (operand_b == '0) dval = ONE_V;
				else if (operand_a == '0) begin
					if (operand_b[W-1]) ctl.status = cka_pkg::ST_ZERO;
				end else if (operand_a == ONE_V) dval = ONE_V;
				else if (operand_a == '1) dval = operand_b[0] ? '1 : ONE_V;
				else if (operand_b[W-1]) dval = '0;
				// base magnitude of two or more overflows past this exponent
				else if (mb >= WCNT) ctl.status = cka_pkg::ST_RANGE;
				else begin
					ctl.direct = 1'b0;
					ctl.neg    = operand_a[W-1] & operand_b[0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl;
			ma_s1   <= ma;
			mb_s1   <= mb;
			dval_s1 <= dval;
		end
	end
endmodule
`default_nettype wire

>>> rtl/cka_cell.sv
// one chain cell: a restoring divide step, a shift-add multiply step
// and one power multiply step; depends on cka_pkg
`timescale 1ns / 1ps
`default_nettype none
module cka_cell #(
	parameter int W   = cka_pkg::DATA_WIDTH,
	parameter int IDX = 0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               valid_i,
	input  cka_pkg::ctl_t     ctl_i,
	input  wire  [W-1:0]      ma_i,
	input  wire  [W-1:0]      mb_i,
	input  wire  [W-1:0]      dvd_i,
	input  wire  [W-1:0]      rem_i,
	input  wire  [2*W-1:0]    prod_i,
	input  wire  [W-1:0]      acc_i,
	input  wire               povf_i,
	input  wire  [W-1:0]      dval_i,
	output logic              valid_q,
	output cka_pkg::ctl_t     ctl_q,
	output logic [W-1:0]      ma_q,
	output logic [W-1:0]      mb_q,
	output logic [W-1:0]      dvd_q,
	output logic [W-1:0]      rem_q,
	output logic [2*W-1:0]    prod_q,
	output logic [W-1:0]      acc_q,
	output logic              povf_q,
	output logic [W-1:0]      dval_q
);
	localparam logic [W-1:0]   IDX_V   = W'(IDX);
	localparam logic [2*W-1:0] POW_LIM = (2*W)'(1) << (W-1);

	logic [W-1:0]   rem_sh;
	logic           ge;
	logic [2*W-1:0] full;
	logic           pstep;

	// remainder stays below the divisor, so its top bit is always clear
	assign rem_sh = {rem_i[W-2:0], dvd_i[W-1]};
	assign ge     = rem_sh >= mb_i;
	assign full   = {{W{1'b0}}, acc_i} * {{W{1'b0}}, ma_i};
	assign pstep  = IDX_V < mb_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q  <= ctl_i;
			ma_q   <= ma_i;
			mb_q   <= mb_i;
			dval_q <= dval_i;
			dvd_q  <= {dvd_i[W-2:0], ge};
			rem_q  <= ge ? (rem_sh - mb_i) : rem_sh;
			prod_q <= mb_i[IDX] ? (prod_i + ({{W{1'b0}}, ma_i} << IDX)) : prod_i;
			acc_q  <= pstep ? full[W-1:0] : acc_i;
			povf_q <= povf_i | (pstep & (full > POW_LIM));
		end
	end
endmodule
`default_nettype wire

>>> rtl/cka_post.sv
// final stage: sign, range check and output register
// depends on cka_pkg
`timescale 1ns / 1ps
`default_nettype none
module cka_post #(
	parameter int W = cka_pkg::DATA_WIDTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               valid_i,
	input  cka_pkg::ctl_t     ctl_i,
	input  wire  [W-1:0]      dvd_i,
	input  wire  [W-1:0]      rem_i,
	input  wire  [2*W-1:0]    prod_i,
	input  wire  [W-1:0]      acc_i,
	input  wire               povf_i,
	input  wire  [W-1:0]      dval_i,
	output logic              valid_q,
	output logic [W-1:0]      value_q,
	output logic [1:0]        status_q
);
	localparam logic [2*W-1:0] NEG_LIM = (2*W)'(1) << (W-1);
	localparam logic [2*W-1:0] POS_LIM = NEG_LIM - (2*W)'(1);

	logic [2*W-1:0] mag, lim;
	logic           ovf;
	logic [W-1:0]   res, val;
	logic [1:0]     st;

	assign lim = ctl_i.neg ? NEG_LIM : POS_LIM;

	always_comb begin
		case (ctl_i.func)
			cka_pkg::FUNC_MUL: mag = prod_i;
			cka_pkg::FUNC_DIV: mag = {{W{1'b0}}, dvd_i};
			cka_pkg::FUNC_MOD: mag = {{W{1'b0}}, rem_i};
			default:           mag = {{W{1'b0}}, acc_i};
		endcase
		ovf = (mag > lim) | ((ctl_i.func == cka_pkg::FUNC_POW) & povf_i);
		res = ctl_i.neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
		if (ctl_i.direct) begin
			st  = ctl_i.status;
			val = dval_i;
		end else begin
			st  = ovf ? cka_pkg::ST_RANGE : cka_pkg::ST_OK;
			val = ovf ? '0 : res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= val;
			status_q <= st;
		end
	end
endmodule
`default_nettype wire

>>> rtl/checked_int32_alu.sv
// checked signed alu: decode stage, a chain of DATA_WIDTH cells, output stage
// one transfer per cycle while the output register is not held
// the chain has one cell per operand bit; all stages move together and
// hold while a result waits in the output register
// reset clears the valid bits of every stage; payload registers are not reset
// depends on cka_pkg, cka_prep, cka_cell, cka_post
`timescale 1ns / 1ps
`default_nettype none
module checked_int32_alu #(
	parameter int DATA_WIDTH = cka_pkg::DATA_WIDTH
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	// func, operand_a, operand_b, zero fill
	input  wire  [((3 + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  wire  m_tready,
	// value, status, zero fill
	output logic [((DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0]    m_tdata
);
	localparam int W     = DATA_WIDTH;
	localparam int OUT_W = ((W + 2 + 7) / 8) * 8;

	logic              en;
	logic              vld   [0:W];
	cka_pkg::ctl_t     ctl   [0:W];
	logic [W-1:0]      ma    [0:W];
	logic [W-1:0]      mb    [0:W];
	logic [W-1:0]      dvd   [0:W];
	logic [W-1:0]      rem   [0:W];
	logic [2*W-1:0]    prod  [0:W];
	logic [W-1:0]      acc   [0:W];
	logic              povf  [0:W];
	logic [W-1:0]      dval  [0:W];
	logic [W-1:0]      value_q;
	logic [1:0]        status_q;

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	cka_prep #(.W(W)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_i  (s_tvalid),
		.func     (s_tdata[2:0]),
		.operand_a(s_tdata[3 +: W]),
		.operand_b(s_tdata[3 + W +: W]),
		.valid_s1 (vld[0]),
		.ctl_s1   (ctl[0]),
		.ma_s1    (ma[0]),
		.mb_s1    (mb[0]),
		.dval_s1  (dval[0])
	);

	// divide starts with the dividend magnitude, power with an accumulator of one
	assign dvd[0]  = ma[0];
	assign rem[0]  = '0;
	assign prod[0] = '0;
	assign acc[0]  = W'(1);
	assign povf[0] = 1'b0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		cka_cell #(.W(W), .IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(vld[i]),
			.ctl_i  (ctl[i]),
			.ma_i   (ma[i]),
			.mb_i   (mb[i]),
			.dvd_i  (dvd[i]),
			.rem_i  (rem[i]),
			.prod_i (prod[i]),
			.acc_i  (acc[i]),
			.povf_i (povf[i]),
			.dval_i (dval[i]),
			.valid_q(vld[i+1]),
			.ctl_q  (ctl[i+1]),
			.ma_q   (ma[i+1]),
			.mb_q   (mb[i+1]),
			.dvd_q  (dvd[i+1]),
			.rem_q  (rem[i+1]),
			.prod_q (prod[i+1]),
			.acc_q  (acc[i+1]),
			.povf_q (povf[i+1]),
			.dval_q (dval[i+1])
		);
	end

	cka_post #(.W(W)) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (vld[W]),
		.ctl_i   (ctl[W]),
		.dvd_i   (dvd[W]),
		.rem_i   (rem[W]),
		.prod_i  (prod[W]),
		.acc_i   (acc[W]),
		.povf_i  (povf[W]),
		.dval_i  (dval[W]),
		.valid_q (m_tvalid),
		.value_q (value_q),
		.status_q(status_q)
	);

	assign m_tdata = OUT_W'({status_q, value_q});
endmodule
`default_nettype wire

>>> sim/checked_int32_alu_test.sv
// testbench for checked_int32_alu: directed and random operand pairs with
// randomized stalls on both sides, checked against an in-bench predictor
// depends on cka_pkg and the checked_int32_alu rtl
`timescale 1ns / 1ps
module checked_int32_alu_test;

	localparam int W = 32;
	localparam int S_BITS = ((3 + 2*W + 7) / 8) * 8;
	localparam int M_BITS = ((W + 2 + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [2:0] FUNC_UNUSED = 3'd7;
	localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] I32_MIN = 32'sh80000000;

	// status sits above value, matching the m_tdata layout
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} alu_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [S_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [M_BITS-1:0] m_tdata;

	alu_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	bit sending_done = 0;

	checked_int32_alu i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] fit_check(input logic signed [65:0] x,
			output logic [1:0] st);
		if (x > 66'(I32_MAX) || x < 66'(I32_MIN)) begin
			st = cka_pkg::ST_RANGE;
			return 0;
		end
		st = cka_pkg::ST_OK;
		return 64'(x);
	endfunction

	function automatic alu_result_t alu_predict(input logic [2:0] f,
			input logic signed [31:0] a, input logic signed [31:0] b);
		alu_result_t r;
		logic signed [65:0] acc;
		logic [1:0] st;
		logic [63:0] v;
		int n;
		st = cka_pkg::ST_OK;
		v = 0;
		case (f)
			cka_pkg::FUNC_CMP: v = (a == b) ? 0 : (a < b ? -1 : 1);
			cka_pkg::FUNC_ADD: v = fit_check(66'(a) + 66'(b), st);
			cka_pkg::FUNC_SUB: v = fit_check(66'(a) - 66'(b), st);
			cka_pkg::FUNC_MUL: v = fit_check(66'(a) * 66'(b), st);
			cka_pkg::FUNC_DIV: begin
				if (b == 0) st = cka_pkg::ST_ZERO;
				else v = fit_check(66'(a) / 66'(b), st);
			end
			cka_pkg::FUNC_MOD: begin
				if (b == 0) st = cka_pkg::ST_ZERO;
				else v = 64'(66'(a) % 66'(b));
			end
			cka_pkg::FUNC_POW: begin
				if (b == 0) v = 1;
				else if (a == 0) begin
					if (b < 0) st = cka_pkg::ST_ZERO;
				end else if (a == 1) v = 1;
				else if (a == -1) v = b[0] ? -1 : 1;
				else if (b > 0) begin
					// |a| >= 2 leaves the range within 32 steps
					acc = 1;
					n = b;
					while (n > 0 && st == cka_pkg::ST_OK) begin
						acc = acc * 66'(a);
						v = fit_check(acc, st);
						n--;
					end
				end
			end
			default: ;
		endcase
		if (st != cka_pkg::ST_OK) v = 0;
		r.value = v[31:0];
		r.status = st;
		return r;
	endfunction

	// tvalid stays high between back-to-back items and drops only for a gap
	task automatic send_op(input logic [2:0] f, input logic [31:0] a,
			input logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {{(S_BITS-67){1'b0}}, b, a, f};
		pending_results.push_back(alu_predict(f, a, b));
		items_sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return I32_MAX;
			1: return I32_MIN;
			2: return $urandom_range(0, 4) - 2;
			3: return $urandom_range(0, 40) - 20;
			4: return $urandom_range(0, 131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed_edges();
		logic [31:0] corner[6];
		corner = '{I32_MAX, I32_MIN, 0, 1, 32'hffffffff, 2};
		for (int f = 0; f <= 7; f++) send_op(f[2:0], corner[f % 6], corner[(f + 3) % 6]);
		send_op(cka_pkg::FUNC_ADD, I32_MAX, 1);
		send_op(cka_pkg::FUNC_SUB, I32_MIN, 1);
		send_op(cka_pkg::FUNC_MUL, 32'h00010000, 32'h00010000);
		send_op(cka_pkg::FUNC_MUL, I32_MIN, 32'hffffffff);
		send_op(cka_pkg::FUNC_MUL, 32'h00008000, 32'hffff0000);
		send_op(cka_pkg::FUNC_DIV, 7, 0);
		send_op(cka_pkg::FUNC_DIV, I32_MIN, 32'hffffffff);
		send_op(cka_pkg::FUNC_DIV, -7, 2);
		send_op(cka_pkg::FUNC_MOD, I32_MIN, 32'hffffffff);
		send_op(cka_pkg::FUNC_MOD, -7, 2);
		send_op(cka_pkg::FUNC_MOD, 5, 0);
		send_op(cka_pkg::FUNC_POW, 0, 0);
		send_op(cka_pkg::FUNC_POW, 0, 32'hfffffffd);
		send_op(cka_pkg::FUNC_POW, 32'hffffffff, 32'hfffffffd);
		send_op(cka_pkg::FUNC_POW, 2, 32'hffffffff);
		send_op(cka_pkg::FUNC_POW, 2, 31);
		send_op(cka_pkg::FUNC_POW, 32'hfffffffe, 31);
		send_op(cka_pkg::FUNC_CMP, I32_MIN, I32_MAX);
	endtask

	task automatic test_random_ops(input int count);
		logic [2:0] f;
		logic [31:0] a, b;
		for (int i = 0; i < count; i++) begin
			f = ($urandom_range(0, 40) == 0) ? FUNC_UNUSED : 3'($urandom_range(0, 6));
			a = pick_operand();
			b = pick_operand();
			if (f == cka_pkg::FUNC_POW && $urandom_range(0, 1)) b = $urandom_range(0, 34);
			send_op(f, a, b);
		end
	endtask

	task automatic test_output_backpressure();
		hold_off = 120;
		test_random_ops(60);
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 6) == 0);
	end

	always @(posedge clk) begin
		alu_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value %h status %0d, expected %h status %0d",
							got.value, got.status, want.value, want.status);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else if (arst_n && (!sending_done || pending_results.size() != 0))
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("checked_int32_alu_test failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed_edges();
		test_random_ops(500);
		test_output_backpressure();
		test_random_ops(560);
		s_tvalid <= 0;
		sending_done = 1;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d items over all operations and the unused code,", items_sent);
		$display("%0d results checked with random stalls and a long output hold-off",
			results_seen);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("checked_int32_alu_test passed");
		else
			$display("checked_int32_alu_test failed");
		$finish;
	end
endmodule
